// ===== src/stt_pkg.sv =====
package stt_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int MS_W        = 20;
    localparam int PERIOD_W    = 32;
    localparam int PROD_W      = PERIOD_W + MS_W;

    localparam logic [63:0]     AUTO_ID_START = 64'h1000;
    localparam logic [MS_W-1:0] NS_PER_MS     = MS_W'(1000000);

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_KILL  = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [63:0]         owner;
        logic [63:0]         event_id;
        logic [PERIOD_W-1:0] period_ms;
        logic [63:0]         callback;
        logic [63:0]         now_ns;
    } stt_req_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] result_id;
        logic [63:0] fired_owner;
        logic [63:0] fired_callback;
    } stt_rsp_t;

    typedef struct packed {
        logic [63:0]         owner;
        logic [63:0]         id;
        logic [PERIOD_W-1:0] period;
        logic [63:0]         callback;
        logic [63:0]         last_time;
    } stt_entry_t;

    // table control from the sequencer
    typedef struct packed {
        logic             we;
        logic             act_set;
        logic             act_clr;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
    } stt_ctl_t;

endpackage

// ===== src/software_timer_table.sv =====
// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_ready  stt_req_t: action, owner, event_id, period_ms, callback, now_ns
// rsp       out  rsp_valid/rsp_ready  stt_rsp_t: ok, result_id, fired_owner, fired_callback
//
// One item at a time; req_ready is high only while the sequencer is idle. The table is
// scanned one entry per cycle through the registered read port of the entry store, except
// that for check an active entry is also evaluated in the due-time unit (S_EVAL) before
// the scan moves on. Ownerless set skips the scan and goes straight to allocation.
// Reset clears all active bits and loads the auto id counter with 0x1000. The result sits in
// an output register; a new item is taken while it waits, only the next hand-over stalls.
module software_timer_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  stt_pkg::stt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output stt_pkg::stt_rsp_t rsp
);
    import stt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_ALLOC = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    stt_req_t         req_reg, req_next;
    logic [63:0]      id_reg, id_next;
    logic [63:0]      auto_id_reg, auto_id_next;
    stt_rsp_t         res_reg, res_next;
    stt_rsp_t         rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    stt_ctl_t         ctl;
    stt_entry_t       wr_data;
    stt_entry_t       rd_entry;
    logic             rd_active;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             due;

    logic             match;
    logic             last;
    logic [IDX_W-1:0] idx_inc;

    stt_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .wr_data    (wr_data),
        .rd_entry   (rd_entry),
        .rd_active  (rd_active),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    // shared due-time unit, fed by the entry under the scan pointer
    stt_due u_due (
        .clk       (clk),
        .now_ns    (req_reg.now_ns),
        .last_time (rd_entry.last_time),
        .period    (rd_entry.period),
        .due       (due)
    );

    assign match   = rd_active && (rd_entry.owner == req_reg.owner)
                     && (rd_entry.id == req_reg.event_id);
    assign last    = (idx_reg == IDX_W'(TIMER_COUNT - 1));
    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        id_next        = id_reg;
        auto_id_next   = auto_id_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        ctl.we      = 1'b0;
        ctl.act_set = 1'b0;
        ctl.act_clr = 1'b0;
        ctl.wr_idx  = idx_reg;
        ctl.rd_idx  = idx_reg;

        // new or refreshed timer starting now
        wr_data.owner     = req_reg.owner;
        wr_data.id        = id_reg;
        wr_data.period    = req_reg.period_ms;
        wr_data.callback  = req_reg.callback;
        wr_data.last_time = req_reg.now_ns;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                ctl.rd_idx = '0;
                if (req_valid)
                begin
                    req_next = req;
                    idx_next = '0;
                    res_next = '0;
                    id_next  = req.event_id;
                    case (req.action)
                        ACT_SET:
                        begin
                            if (req.owner == 64'd0)
                            begin
                                // counter advances even if the table is full
                                id_next      = auto_id_reg;
                                auto_id_next = auto_id_reg + 64'd1;
                                state_next   = S_ALLOC;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ACT_KILL, ACT_CHECK:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                case (req_reg.action)
                    ACT_SET:
                    begin
                        if (match)
                        begin
                            ctl.we             = 1'b1;
                            res_next.ok        = 1'b1;
                            res_next.result_id = id_reg;
                            state_next         = S_DONE;
                        end
                        else if (last)
                        begin
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            ctl.rd_idx = idx_inc;
                        end
                    end
                    ACT_KILL:
                    begin
                        if (match)
                        begin
                            ctl.act_clr = 1'b1;
                            res_next.ok = 1'b1;
                            state_next  = S_DONE;
                        end
                        else if (last)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            ctl.rd_idx = idx_inc;
                        end
                    end
                    default:
                    begin
                        if (rd_active)
                        begin
                            state_next = S_EVAL;
                        end
                        else if (last)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            ctl.rd_idx = idx_inc;
                        end
                    end
                endcase
            end

            S_EVAL:
            begin
                if (due)
                begin
                    ctl.we                  = 1'b1;
                    wr_data                 = rd_entry;
                    wr_data.last_time       = req_reg.now_ns;
                    res_next.ok             = 1'b1;
                    res_next.result_id      = rd_entry.id;
                    res_next.fired_owner    = rd_entry.owner;
                    res_next.fired_callback = rd_entry.callback;
                    state_next              = S_DONE;
                end
                else if (last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    ctl.rd_idx = idx_inc;
                    state_next = S_SCAN;
                end
            end

            S_ALLOC:
            begin
                ctl.wr_idx = free_idx;
                if (free_found)
                begin
                    ctl.we             = 1'b1;
                    ctl.act_set        = 1'b1;
                    res_next.ok        = 1'b1;
                    res_next.result_id = id_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            auto_id_reg   <= AUTO_ID_START;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            auto_id_reg   <= auto_id_next;
            rsp_valid_reg <= rsp_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        id_reg  <= id_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/stt_store.sv =====
module stt_store (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::stt_ctl_t  ctl,
    input  stt_pkg::stt_entry_t wr_data,
    output stt_pkg::stt_entry_t rd_entry,
    output logic               rd_active,
    output logic               free_found,
    output logic [stt_pkg::IDX_W-1:0] free_idx
);
    import stt_pkg::*;

    stt_entry_t             entry_mem_reg [TIMER_COUNT];
    stt_entry_t             rd_entry_reg;
    logic                   rd_active_reg;
    logic [TIMER_COUNT-1:0] active_reg;

    // entry payload, no reset; inactive entries are never looked at
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            entry_mem_reg[ctl.wr_idx] <= wr_data;
        end
        rd_entry_reg <= entry_mem_reg[ctl.rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            rd_active_reg <= 1'b0;
        end
        else
        begin
            rd_active_reg <= active_reg[ctl.rd_idx];
            if (ctl.act_set)
            begin
                active_reg[ctl.wr_idx] <= 1'b1;
            end
            else if (ctl.act_clr)
            begin
                active_reg[ctl.wr_idx] <= 1'b0;
            end
        end
    end

    // lowest free entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign rd_entry  = rd_entry_reg;
    assign rd_active = rd_active_reg;

endmodule

// ===== src/stt_due.sv =====
module stt_due (
    input  logic                          clk,
    input  logic [63:0]                   now_ns,
    input  logic [63:0]                   last_time,
    input  logic [stt_pkg::PERIOD_W-1:0]  period,
    output logic                          due
);
    import stt_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [63:0]       diff_reg;

    // floor(diff / 1e6) >= period  <=>  diff >= period * 1e6
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(period) * PROD_W'(NS_PER_MS);
        diff_reg <= now_ns - last_time;
    end

    assign due = (diff_reg >= 64'(prod_reg));

endmodule

// ===== dv/tb_software_timer_table.sv =====
// Checks the timer table against an in-bench model of its entries.
// Requests go through a bursty sender; responses are taken by a receiver that
// stalls on a pattern of its own. Every response is compared with the model.
module tb_software_timer_table;

    import stt_pkg::*;

    // Action code the block must answer with all-zero fields
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [63:0] MS_IN_NS   = 64'd1_000_000;
    localparam int          RANDOM_ITEMS = 850;

    // Receiver back-pressure patterns
    typedef enum int
    {
        RX_FREE,        // always ready
        RX_COIN,        // ready half the time
        RX_SPARSE,      // ready one cycle in five, on average
        RX_PERIODIC     // ready a quarter of the time, in a repeating pattern
    } rx_pattern_t;

    // ------------------------------------------------------------------
    // Model of the timer table. note_request() advances the table on each
    // accepted request and queues the response it must produce;
    // check_response() compares a delivered response with the oldest one.
    // ------------------------------------------------------------------
    class timer_table_model;
        bit          active    [TIMER_COUNT];
        logic [63:0] owner     [TIMER_COUNT];
        logic [63:0] timer_id  [TIMER_COUNT];
        logic [31:0] period    [TIMER_COUNT];
        logic [63:0] callback  [TIMER_COUNT];
        logic [63:0] start_ns  [TIMER_COUNT];
        logic [63:0] auto_id;
        stt_rsp_t    expected_rsps[$];
        int          error_count;

        function new();
            foreach (active[i])
            begin
                active[i] = 1'b0;
            end
            auto_id     = AUTO_ID_START;
            error_count = 0;
        endfunction

        // lowest active entry with this key, or -1
        function int find_timer(logic [63:0] own, logic [63:0] ev);
            foreach (active[i])
            begin
                if (active[i] && owner[i] == own && timer_id[i] == ev)
                    return i;
            end
            return -1;
        endfunction

        function stt_rsp_t predict(stt_req_t r);
            stt_rsp_t    rsp;
            logic [63:0] new_id;
            int          slot;
            rsp  = '0;
            slot = -1;
            case (r.action)
                ACT_SET:
                begin
                    new_id = r.event_id;
                    if (r.owner != 64'd0)
                    begin
                        slot = find_timer(r.owner, r.event_id);
                    end
                    else
                    begin
                        // ownerless: counter advances even if the table is full
                        new_id  = auto_id;
                        auto_id = auto_id + 64'd1;
                    end
                    if (slot >= 0)
                    begin
                        period[slot]   = r.period_ms;
                        callback[slot] = r.callback;
                        start_ns[slot] = r.now_ns;
                        rsp.ok         = 1'b1;
                        rsp.result_id  = r.event_id;
                    end
                    else
                    begin
                        foreach (active[i])
                        begin
                            if (slot < 0 && !active[i])
                                slot = i;
                        end
                        if (slot >= 0)
                        begin
                            active[slot]   = 1'b1;
                            owner[slot]    = r.owner;
                            timer_id[slot] = new_id;
                            period[slot]   = r.period_ms;
                            callback[slot] = r.callback;
                            start_ns[slot] = r.now_ns;
                            rsp.ok         = 1'b1;
                            rsp.result_id  = new_id;
                        end
                    end
                end
                ACT_KILL:
                begin
                    slot = find_timer(r.owner, r.event_id);
                    if (slot >= 0)
                    begin
                        active[slot] = 1'b0;
                        rsp.ok       = 1'b1;
                    end
                end
                ACT_CHECK:
                begin
                    foreach (active[i])
                    begin
                        // elapsed time wraps modulo 2^64
                        if (slot < 0 && active[i] &&
                            (r.now_ns - start_ns[i]) / MS_IN_NS >= {32'd0, period[i]})
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        start_ns[slot]     = r.now_ns;
                        rsp.ok             = 1'b1;
                        rsp.result_id      = timer_id[slot];
                        rsp.fired_owner    = owner[slot];
                        rsp.fired_callback = callback[slot];
                    end
                end
                default:
                begin
                end
            endcase
            return rsp;
        endfunction

        function void note_request(stt_req_t r);
            expected_rsps.push_back(predict(r));
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_response(stt_rsp_t got);
            stt_rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("response with nothing outstanding: 0x%0h", got);
                error_count++;
                return;
            end
            want = expected_rsps.pop_front();
            compare_field("ok", {63'd0, want.ok}, {63'd0, got.ok});
            compare_field("result_id", want.result_id, got.result_id);
            compare_field("fired_owner", want.fired_owner, got.fired_owner);
            compare_field("fired_callback", want.fired_callback, got.fired_callback);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------
    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    stt_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    stt_rsp_t rsp;

    software_timer_table DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    timer_table_model model = new();

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    int          burst_left   = 1;
    logic [63:0] auto_issued  = 64'd0;   // ownerless sets sent so far
    logic [63:0] clock_ns     = 64'd0;   // running time for the random part
    logic [63:0] owner_pool [6];
    logic [63:0] event_pool [8];

    function automatic stt_req_t make_req(logic [1:0] act, logic [63:0] own,
                                          logic [63:0] ev, logic [31:0] per,
                                          logic [63:0] cb, logic [63:0] now);
        stt_req_t r;
        r.action    = act;
        r.owner     = own;
        r.event_id  = ev;
        r.period_ms = per;
        r.callback  = cb;
        r.now_ns    = now;
        return r;
    endfunction

    // Present one item and hold it until the block takes it. The sender runs
    // in bursts; valid drops only when a real gap follows, so it is never
    // lowered and raised in the same step.
    task automatic send_req(input stt_req_t item);
        int gap;
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        if (item.action == ACT_SET && item.owner == 64'd0)
            auto_issued = auto_issued + 64'd1;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Mostly keys from small pools so that refresh and kill hit live timers;
    // one in ten is a fully random key.
    function automatic logic [63:0] pick_owner();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return 64'd0;
        if (roll == 9)
            return {$urandom, $urandom};
        return owner_pool[$urandom_range(0, 5)];
    endfunction

    function automatic stt_req_t random_req();
        stt_req_t    r;
        int          roll;
        logic [1:0]  act;
        logic [63:0] own;
        logic [63:0] ev;
        logic [31:0] per;

        // time moves forward by up to 3 ms; now and then it jumps anywhere,
        // which also gives backward steps and wrapped differences
        if ($urandom_range(0, 49) == 0)
            clock_ns = {$urandom, $urandom};
        else
            clock_ns = clock_ns + $urandom_range(0, 3_000_000);

        roll = $urandom_range(0, 99);
        if (roll < 35)
            act = ACT_SET;
        else if (roll < 60)
            act = ACT_KILL;
        else if (roll < 96)
            act = ACT_CHECK;
        else
            act = ACT_UNUSED;

        own = pick_owner();
        ev  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : event_pool[$urandom_range(0, 7)];
        // kills of ownerless timers aim at recently issued auto ids
        if (act == ACT_KILL && own == 64'd0)
            ev = AUTO_ID_START + auto_issued - 64'($urandom_range(1, 16));
        per = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
        r   = make_req(act, own, ev, per, {$urandom, $urandom}, clock_ns);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and receiver. Both sides are sampled at the rising edge, so
    // what is seen here is what the block saw at that edge.
    // ------------------------------------------------------------------
    rx_pattern_t rx_pattern = RX_FREE;
    int          pattern_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                model.note_request(req);
            if (rsp_valid && rsp_ready)
                model.check_response(rsp);
        end

        if (pattern_left == 0)
        begin
            rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (rx_pattern)
            RX_FREE:     rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 4) == 0);
            RX_PERIODIC: rsp_ready <= ((pattern_left % 16) < 4);
            default:     rsp_ready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        foreach (owner_pool[i])
            owner_pool[i] = {$urandom, $urandom} | 64'd1;   // never ownerless
        owner_pool[0] = '1;
        foreach (event_pool[i])
            event_pool[i] = {$urandom, $urandom};
        event_pool[0] = 64'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table: nothing to fire, unused action does nothing
        send_req(make_req(ACT_CHECK, 64'd0, 64'd0, 32'd0, 64'd0, 64'd0));
        send_req(make_req(ACT_UNUSED, '1, '1, '1, '1, '1));
        send_req(make_req(ACT_KILL, 64'd5, 64'd7, 32'd0, 64'd0, 64'd0));
        // ownerless set takes the first auto id; period zero is always due
        send_req(make_req(ACT_SET, 64'd0, 64'd123, 32'd0, '1, 64'd0));
        send_req(make_req(ACT_CHECK, 64'd0, 64'd0, 32'd0, 64'd0, 64'd0));
        // all-ones key and period, then a refresh of the same key
        send_req(make_req(ACT_SET, '1, '1, '1, 64'hA5A5_A5A5_A5A5_A5A5, '1));
        send_req(make_req(ACT_SET, '1, '1, 32'd5, 64'h5A5A_5A5A_5A5A_5A5A, '1));
        // event id zero still counts as success
        send_req(make_req(ACT_SET, 64'd1, 64'd0, 32'd1, 64'd0, '1));
        // kill of an ownerless timer by owner zero and its auto id
        send_req(make_req(ACT_KILL, 64'd0, AUTO_ID_START, 32'd0, 64'd0, 64'd0));
        // elapsed time across the 2^64 wrap: 4 ms, then exactly 5 ms
        send_req(make_req(ACT_CHECK, 64'd0, 64'd0, 32'd0, 64'd0, 64'd4_999_998));
        send_req(make_req(ACT_CHECK, 64'd0, 64'd0, 32'd0, 64'd0, 64'd4_999_999));
        // fill the table with keys the random part can find again
        for (int i = 0; i < TIMER_COUNT - 2; i++)
            send_req(make_req(ACT_SET, owner_pool[i % 6], event_pool[i % 8], 32'd3,
                              {$urandom, $urandom}, 64'd5_000_000));
        // full table: ownerless set fails but still consumes an auto id
        send_req(make_req(ACT_SET, 64'd0, 64'd0, 32'd2, 64'd77, 64'd5_000_000));
        send_req(make_req(ACT_KILL, owner_pool[0], event_pool[0], 32'd0, 64'd0, 64'd0));
        send_req(make_req(ACT_SET, 64'd0, 64'd0, 32'd2, 64'd78, 64'd5_000_000));

        clock_ns = 64'd5_000_000;
        repeat (RANDOM_ITEMS) send_req(random_req());
        req_valid <= 1'b0;

        // let the monitor log the last item, then drain
        @(posedge clk);
        while (model.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (model.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
